>>> hw/rtl/crlt_pkg.sv
// Package for the client resource lock table.
// Request, response, controller command and status types, plus op and status codes.
// No dependencies.
package crlt_pkg;

  typedef enum logic [2:0] {
    OP_REGISTER = 3'd0,
    OP_POSITION = 3'd1,
    OP_RESERVE  = 3'd2,
    OP_RELEASE  = 3'd3,
    OP_MISSION  = 3'd4,
    OP_SILENT   = 3'd5,
    OP_UNKNOWN  = 3'd6
  } op_e;

  typedef enum logic [3:0] {
    ST_REGISTERED    = 4'd0,
    ST_POS_OK        = 4'd1,
    ST_RESERVED      = 4'd2,
    ST_RELEASED      = 4'd3,
    ST_MISSION       = 4'd4,
    ST_DUP           = 4'd5,
    ST_FULL          = 4'd6,
    ST_UNREG         = 4'd7,
    ST_POS_MISSING   = 4'd8,
    ST_HELD_OTHER    = 4'd9,
    ST_NOT_HOLDER    = 4'd10,
    ST_ALREADY_YOURS = 4'd11,
    ST_BAD           = 4'd12
  } status_e;

  localparam int unsigned AddrW = 48;
  localparam int unsigned PosW  = 32;
  localparam int unsigned ResW  = 16;
  localparam logic [1:0]  PosAll = 2'd3;

  typedef struct packed {
    op_e                     op;
    logic [AddrW-1:0]        client_addr;
    logic [1:0]              pos_count;
    logic signed [PosW-1:0]  pos_x;
    logic signed [PosW-1:0]  pos_y;
    logic signed [PosW-1:0]  pos_z;
    logic                    res_present;
    logic signed [ResW-1:0]  resource_id;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic signed [ResW-1:0] resource_echo;
    logic                   echo_valid;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic exec;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } sts_t;

endpackage

>>> hw/rtl/crlt_if.sv
// Valid/ready channel interfaces for request and response transfers.
// Depends on crlt_pkg for the payload widths and codes.
interface crlt_req_if
  import crlt_pkg::*;
();
  logic                   valid;
  logic                   ready;
  op_e                    op;
  logic [AddrW-1:0]       client_addr;
  logic [1:0]             pos_count;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] pos_z;
  logic                   res_present;
  logic signed [ResW-1:0] resource_id;

  modport source (
    output valid, op, client_addr, pos_count, pos_x, pos_y, pos_z, res_present,
           resource_id,
    input  ready
  );
  modport sink (
    input  valid, op, client_addr, pos_count, pos_x, pos_y, pos_z, res_present,
           resource_id,
    output ready
  );
endinterface

interface crlt_rsp_if
  import crlt_pkg::*;
();
  logic                   valid;
  logic                   ready;
  status_e                status;
  logic signed [ResW-1:0] resource_echo;
  logic                   echo_valid;

  modport source (output valid, status, resource_echo, echo_valid, input ready);
  modport sink (input valid, status, resource_echo, echo_valid, output ready);
endinterface

>>> hw/rtl/crlt_ctrl.sv
// Controller FSM: accept a request, run the client scan, execute, hand to output.
// Depends on crlt_pkg (cmd_t, sts_t).
module crlt_ctrl
  import crlt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   rdy_q;

  assign in_ready_o = rdy_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = rdy_q & in_valid_i;
    cmd_o.scan_step = (state_q == S_SCAN);
    cmd_o.exec      = (state_q == S_EXEC) & ~sts_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (rdy_q && in_valid_i) begin
            state_q <= S_SCAN;
            rdy_q   <= 1'b0;
          end
        end
        S_SCAN: begin
          if (sts_i.scan_done) state_q <= S_EXEC;
        end
        S_EXEC: begin
          // hold while the previous response is still waiting
          if (!sts_i.out_busy) begin
            state_q <= S_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          rdy_q   <= 1'b1;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/crlt_dpath.sv
// Datapath: client address table with sequential scan, position and mission stores,
// resource held bits and owner memory, decision logic and the response register.
// Depends on crlt_pkg.
module crlt_dpath
  import crlt_pkg::*;
#(
  parameter int unsigned MAX_CLIENTS   = 8,
  parameter int unsigned NUM_RESOURCES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned CW  = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int unsigned SIW = $clog2(MAX_CLIENTS + 1);
  localparam int unsigned RW  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

  // storage
  logic [AddrW-1:0] addr_mem [MAX_CLIENTS];
  logic [PosW-1:0]  posx_mem [MAX_CLIENTS];
  logic [PosW-1:0]  posy_mem [MAX_CLIENTS];
  logic [PosW-1:0]  posz_mem [MAX_CLIENTS];
  logic [CW-1:0]    owner_mem [NUM_RESOURCES];
  logic [MAX_CLIENTS-1:0]   valid_q;
  logic [MAX_CLIENTS-1:0]   mission_q;
  logic [NUM_RESOURCES-1:0] held_q;

  req_t             req_q;
  logic [SIW-1:0]   scan_idx_q;
  logic [CW-1:0]    cmp_idx_q;
  logic             cmp_vld_q;
  logic [AddrW-1:0] addr_rd_q;
  logic [CW-1:0]    owner_rd_q;
  logic             hit_q, free_q;
  logic [CW-1:0]    hit_slot_q, free_slot_q;

  logic             out_vld_q;
  rsp_t             rsp_q;

  logic scan_more;
  assign scan_more = (scan_idx_q < SIW'(MAX_CLIENTS));

  logic [RW-1:0] rid_idx;
  logic          rid_ok;
  assign rid_idx = req_q.resource_id[RW-1:0];
  assign rid_ok  = ~req_q.resource_id[ResW-1] &&
                   (req_q.resource_id < ResW'(NUM_RESOURCES));

  assign sts_o.scan_done = ~scan_more & ~cmp_vld_q;
  assign sts_o.out_busy  = out_vld_q & ~out_ready_i;

  assign out_valid_o = out_vld_q;
  assign rsp_o       = rsp_q;

  // decision
  logic emit;
  rsp_t res;
  logic wr_client, px_we, py_we, pz_we, mission_set, held_set, held_clr;

  always_comb begin
    emit        = 1'b1;
    res         = '{status: ST_BAD, resource_echo: '0, echo_valid: 1'b0};
    wr_client   = 1'b0;
    px_we       = 1'b0;
    py_we       = 1'b0;
    pz_we       = 1'b0;
    mission_set = 1'b0;
    held_set    = 1'b0;
    held_clr    = 1'b0;
    if (req_q.op == OP_REGISTER) begin
      if (hit_q) begin
        res.status = ST_DUP;
      end else if (free_q) begin
        res.status = ST_REGISTERED;
        wr_client  = 1'b1;
      end else begin
        res.status = ST_FULL;
      end
    end else if (!hit_q) begin
      res.status = ST_UNREG;
    end else begin
      case (req_q.op) inside
        OP_POSITION: begin
          px_we      = (req_q.pos_count >= 2'd1);
          py_we      = (req_q.pos_count >= 2'd2);
          pz_we      = (req_q.pos_count == PosAll);
          res.status = (req_q.pos_count == PosAll) ? ST_POS_OK : ST_POS_MISSING;
        end
        OP_RESERVE, OP_RELEASE: begin
          if (req_q.res_present) begin
            res.resource_echo = req_q.resource_id;
            res.echo_valid    = 1'b1;
            if (!rid_ok) begin
              res.status = ST_BAD;
            end else if (req_q.op == OP_RESERVE) begin
              if (held_q[rid_idx]) begin
                res.status = (owner_rd_q == hit_slot_q) ? ST_ALREADY_YOURS
                                                        : ST_HELD_OTHER;
              end else begin
                res.status = ST_RESERVED;
                held_set   = 1'b1;
              end
            end else begin
              if (held_q[rid_idx] && owner_rd_q == hit_slot_q) begin
                res.status = ST_RELEASED;
                held_clr   = 1'b1;
              end else begin
                res.status = ST_NOT_HOLDER;
              end
            end
          end
        end
        OP_MISSION: begin
          res.status  = ST_MISSION;
          mission_set = 1'b1;
        end
        OP_SILENT: emit = 1'b0;
        default:   res.status = ST_BAD;
      endcase
    end
  end

  logic do_exec;
  assign do_exec = cmd_i.exec;

  logic [CW-1:0] wslot;
  assign wslot = wr_client ? free_slot_q : hit_slot_q;

  // request latch, scan pipeline, memory reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (scan_more) addr_rd_q <= addr_mem[scan_idx_q[CW-1:0]];
    cmp_idx_q  <= scan_idx_q[CW-1:0];
    owner_rd_q <= owner_mem[rid_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q  <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      hit_slot_q  <= '0;
      free_slot_q <= '0;
    end else if (cmd_i.load) begin
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
    end else if (cmd_i.scan_step) begin
      cmp_vld_q <= scan_more;
      if (scan_more) scan_idx_q <= scan_idx_q + SIW'(1);
      if (cmp_vld_q) begin
        if (valid_q[cmp_idx_q] && addr_rd_q == req_q.client_addr && !hit_q) begin
          hit_q      <= 1'b1;
          hit_slot_q <= cmp_idx_q;
        end
        // lowest free slot for a register request
        if (!valid_q[cmp_idx_q] && !free_q) begin
          free_q      <= 1'b1;
          free_slot_q <= cmp_idx_q;
        end
      end
    end
  end

  // table writes
  always_ff @(posedge clk_i) begin
    if (do_exec) begin
      if (wr_client) addr_mem[free_slot_q] <= req_q.client_addr;
      if (wr_client || px_we) posx_mem[wslot] <= wr_client ? '0 : req_q.pos_x;
      if (wr_client || py_we) posy_mem[wslot] <= wr_client ? '0 : req_q.pos_y;
      if (wr_client || pz_we) posz_mem[wslot] <= wr_client ? '0 : req_q.pos_z;
      if (held_set) owner_mem[rid_idx] <= hit_slot_q;
      else if (held_clr) owner_mem[rid_idx] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      held_q    <= '0;
      mission_q <= '0;
    end else if (do_exec) begin
      if (wr_client) begin
        valid_q[free_slot_q]   <= 1'b1;
        mission_q[free_slot_q] <= 1'b0;
      end
      if (mission_set) mission_q[hit_slot_q] <= 1'b1;
      if (held_set) held_q[rid_idx] <= 1'b1;
      else if (held_clr) held_q[rid_idx] <= 1'b0;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (do_exec && emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_exec && emit) rsp_q <= res;
  end

endmodule

>>> hw/rtl/client_resource_lock_table_unit.sv
// Client resource lock table: a semaphore table for registered clients.
// Request channel (req_i): op, sender address, position fields, resource id.
// Response channel (rsp_o): status, echoed resource id and its valid flag.
// Both channels transfer on a clock edge with valid and ready high.
// Each request scans the client address table one entry per cycle out of a
// single-port memory. Ready drops at the request transfer and returns once the
// scan and the execute step are done, so a new request is taken only after the
// last one has executed.
// The response register is loaded at the same edge at which ready returns.
// A silent ack from a registered client gives no response.
// A waiting response does not block the next request; only the execute step of
// the following request holds until the response register has been taken.
// Reset clears the client valid bits and the resource held bits; nothing else
// needs clearing, so the block is ready right after reset.
// Depends on crlt_pkg, crlt_if, crlt_ctrl, crlt_dpath.
module client_resource_lock_table_unit
  import crlt_pkg::*;
#(
  parameter int unsigned MAX_CLIENTS   = 8,
  parameter int unsigned NUM_RESOURCES = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  crlt_req_if.sink   req_i,
  crlt_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;
  req_t req;
  rsp_t rsp;

  assign req = '{
    op:          req_i.op,
    client_addr: req_i.client_addr,
    pos_count:   req_i.pos_count,
    pos_x:       req_i.pos_x,
    pos_y:       req_i.pos_y,
    pos_z:       req_i.pos_z,
    res_present: req_i.res_present,
    resource_id: req_i.resource_id
  };

  crlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crlt_dpath #(
    .MAX_CLIENTS   (MAX_CLIENTS),
    .NUM_RESOURCES (NUM_RESOURCES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .rsp_o       (rsp)
  );

  assign rsp_o.status        = rsp.status;
  assign rsp_o.resource_echo = rsp.resource_echo;
  assign rsp_o.echo_valid    = rsp.echo_valid;

endmodule

>>> verif/tb_client_resource_lock_table_unit.sv
// Self-checking testbench for client_resource_lock_table_unit: directed table, then random
// traffic over a small client address pool, with random stalls on both channels.
// Depends on crlt_pkg, crlt_if and the RTL of the lock table unit.
module tb_client_resource_lock_table_unit;
  import crlt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxClients   = 8;
  localparam int unsigned NumResources = 16;
  localparam int unsigned PoolSize     = 10;
  localparam int unsigned RandItems    = 1000;
  localparam int unsigned BlockItems   = 100;
  localparam int unsigned DrainCycles  = 4 * (MaxClients + 4);
  localparam int unsigned CycleLimit   = 400000;

  typedef struct {
    req_t req;
    bit   typed;
    bit   has;
    rsp_t rsp;
  } dir_row_t;

  typedef struct {
    bit   typed;
    bit   has;
    rsp_t rsp;
  } fixed_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  crlt_req_if req_if ();
  crlt_rsp_if rsp_if ();

  client_resource_lock_table_unit #(
    .MAX_CLIENTS  (MaxClients),
    .NUM_RESOURCES(NumResources)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the client and resource tables
  bit              slot_used  [MaxClients];
  logic [AddrW-1:0] slot_addr [MaxClients];
  logic [PosW-1:0] slot_pos_x [MaxClients];
  logic [PosW-1:0] slot_pos_y [MaxClients];
  logic [PosW-1:0] slot_pos_z [MaxClients];
  bit              slot_mission[MaxClients];
  bit              res_locked [NumResources];
  int unsigned     res_holder [NumResources];

  dir_row_t        dir_rows[$];
  fixed_reply_t    fixed_reply_q[$];
  rsp_t            reply_due_q[$];
  logic [AddrW-1:0] addr_pool[PoolSize];

  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int cycle_cnt     = 0;
  int accepted_cnt  = 0;
  int silent_cnt    = 0;
  int checked_cnt   = 0;
  int mismatch_cnt  = 0;
  int unexpected_cnt = 0;
  int reported_cnt  = 0;

  function automatic int find_slot(input logic [AddrW-1:0] addr);
    for (int i = 0; i < MaxClients; i++) begin
      if (slot_used[i] && slot_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // Returns 1 when the request produces a reply, and updates the shadow tables.
  function automatic bit lock_table_reply(input req_t r, output rsp_t o);
    int slot;
    int rid;
    o = '{status: ST_BAD, resource_echo: '0, echo_valid: 1'b0};
    if (r.op == OP_REGISTER) begin
      if (find_slot(r.client_addr) >= 0) begin
        o.status = ST_DUP;
        return 1'b1;
      end
      for (int i = 0; i < MaxClients; i++) begin
        if (!slot_used[i]) begin
          slot_used[i]    = 1'b1;
          slot_addr[i]    = r.client_addr;
          slot_pos_x[i]   = '0;
          slot_pos_y[i]   = '0;
          slot_pos_z[i]   = '0;
          slot_mission[i] = 1'b0;
          o.status = ST_REGISTERED;
          return 1'b1;
        end
      end
      o.status = ST_FULL;
      return 1'b1;
    end
    slot = find_slot(r.client_addr);
    if (slot < 0) begin
      o.status = ST_UNREG;
      return 1'b1;
    end
    case (r.op)
      OP_POSITION: begin
        if (r.pos_count >= 2'd1) slot_pos_x[slot] = r.pos_x;
        if (r.pos_count >= 2'd2) slot_pos_y[slot] = r.pos_y;
        if (r.pos_count >= 2'd3) slot_pos_z[slot] = r.pos_z;
        o.status = (r.pos_count == PosAll) ? ST_POS_OK : ST_POS_MISSING;
      end
      OP_RESERVE, OP_RELEASE: begin
        if (!r.res_present) return 1'b1;
        rid = int'(r.resource_id);
        o.resource_echo = r.resource_id;
        o.echo_valid    = 1'b1;
        if (rid < 0 || rid >= int'(NumResources)) return 1'b1;
        if (r.op == OP_RESERVE) begin
          if (res_locked[rid]) begin
            o.status = (res_holder[rid] == slot) ? ST_ALREADY_YOURS : ST_HELD_OTHER;
          end else begin
            res_locked[rid] = 1'b1;
            res_holder[rid] = slot;
            o.status = ST_RESERVED;
          end
        end else if (res_locked[rid] && res_holder[rid] == slot) begin
          res_locked[rid] = 1'b0;
          res_holder[rid] = 0;
          o.status = ST_RELEASED;
        end else begin
          o.status = ST_NOT_HOLDER;
        end
      end
      OP_MISSION: begin
        slot_mission[slot] = 1'b1;
        o.status = ST_MISSION;
      end
      OP_SILENT: return 1'b0;
      default: o.status = ST_BAD;
    endcase
    return 1'b1;
  endfunction

  function automatic void dir_row(input op_e op, input logic [AddrW-1:0] addr,
                                  input logic [1:0] cnt, input logic [PosW-1:0] x,
                                  input logic [PosW-1:0] y, input logic [PosW-1:0] z,
                                  input logic rp, input logic [ResW-1:0] rid,
                                  input bit typed, input bit has, input status_e st,
                                  input logic [ResW-1:0] echo, input logic ev);
    dir_row_t row;
    row.req   = '{op: op, client_addr: addr, pos_count: cnt, pos_x: x, pos_y: y, pos_z: z,
                  res_present: rp, resource_id: rid};
    row.typed = typed;
    row.has   = has;
    row.rsp   = '{status: st, resource_echo: echo, echo_valid: ev};
    dir_rows.push_back(row);
  endfunction

  function automatic req_t rand_request();
    req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)      r.op = OP_REGISTER;
    else if (pick < 25) r.op = OP_POSITION;
    else if (pick < 55) r.op = OP_RESERVE;
    else if (pick < 80) r.op = OP_RELEASE;
    else if (pick < 88) r.op = OP_MISSION;
    else if (pick < 95) r.op = OP_SILENT;
    else                r.op = OP_UNKNOWN;
    // mostly known clients, some stray senders
    if ($urandom_range(0, 9) != 0) r.client_addr = addr_pool[$urandom_range(0, PoolSize - 1)];
    else                           r.client_addr = {16'($urandom()), $urandom()};
    r.pos_count   = 2'($urandom_range(0, 3));
    r.pos_x       = 32'($urandom());
    r.pos_y       = 32'($urandom());
    r.pos_z       = 32'($urandom());
    r.res_present = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 4) != 0) r.resource_id = 16'($urandom_range(0, NumResources - 1));
    else                           r.resource_id = 16'($urandom());
    return r;
  endfunction

  // Drive one request and return at the edge of its transfer; valid stays high.
  task automatic send_request(input req_t r, input bit typed, input bit has, input rsp_t e);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    fixed_reply_q.push_back('{typed: typed, has: has, rsp: e});
    req_if.op          <= r.op;
    req_if.client_addr <= r.client_addr;
    req_if.pos_count   <= r.pos_count;
    req_if.pos_x       <= r.pos_x;
    req_if.pos_y       <= r.pos_y;
    req_if.pos_z       <= r.pos_z;
    req_if.res_present <= r.res_present;
    req_if.resource_id <= r.resource_id;
    req_if.valid       <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Hold off the sender until every outstanding reply has come back.
  task automatic drain_replies();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (reply_due_q.size() != 0) @(posedge clk_i);
  endtask

  // Request monitor: predict the reply of each transfer
  always @(posedge clk_i) begin : req_monitor
    req_t         cur;
    rsp_t         pred;
    bit           has;
    fixed_reply_t note;
    if (rst_ni && req_if.valid && req_if.ready) begin
      cur.op          = req_if.op;
      cur.client_addr = req_if.client_addr;
      cur.pos_count   = req_if.pos_count;
      cur.pos_x       = req_if.pos_x;
      cur.pos_y       = req_if.pos_y;
      cur.pos_z       = req_if.pos_z;
      cur.res_present = req_if.res_present;
      cur.resource_id = req_if.resource_id;
      note = fixed_reply_q.pop_front();
      has  = lock_table_reply(cur, pred);
      if (note.typed) begin
        has  = note.has;
        pred = note.rsp;
      end
      if (has) reply_due_q.push_back(pred);
      else     silent_cnt++;
      accepted_cnt++;
    end
  end

  // Response side: random ready stalls, compare each transfer with the oldest expectation
  initial begin : rsp_sink
    int unsigned gap;
    rsp_t        want;
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      if (reply_due_q.size() == 0) begin
        unexpected_cnt++;
        if (reported_cnt < 10) begin
          reported_cnt++;
          $display("unexpected reply: status %0d echo %0d echo_valid %0b",
                   rsp_if.status, rsp_if.resource_echo, rsp_if.echo_valid);
        end
      end else begin
        want = reply_due_q.pop_front();
        checked_cnt++;
        if (rsp_if.status !== want.status || rsp_if.resource_echo !== want.resource_echo ||
            rsp_if.echo_valid !== want.echo_valid) begin
          mismatch_cnt++;
          if (reported_cnt < 10) begin
            reported_cnt++;
            $display("reply %0d: status exp %0d got %0d, echo exp %0d got %0d, %s %0b got %0b",
                     checked_cnt, want.status, rsp_if.status, want.resource_echo,
                     rsp_if.resource_echo, "echo_valid exp", want.echo_valid,
                     rsp_if.echo_valid);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout with %0d replies outstanding", reply_due_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    localparam logic [AddrW-1:0] AddrLo = '0;
    localparam logic [AddrW-1:0] AddrHi = '1;
    int   err_total;
    rsp_t none;
    none = '{status: ST_BAD, resource_echo: '0, echo_valid: 1'b0};
    req_if.valid       = 1'b0;
    req_if.op          = OP_REGISTER;
    req_if.client_addr = '0;
    req_if.pos_count   = '0;
    req_if.pos_x       = '0;
    req_if.pos_y       = '0;
    req_if.pos_z       = '0;
    req_if.res_present = 1'b0;
    req_if.resource_id = '0;

    addr_pool[0] = AddrLo;
    addr_pool[1] = AddrHi;
    for (int i = 2; i < PoolSize; i++) addr_pool[i] = {16'($urandom()), $urandom()};

    // op, addr, count, x, y, z, res_present, rid | typed, has, status, echo, echo_valid
    dir_row(OP_POSITION, AddrLo, 2'd3, '0, '0, '0, 1'b0, '0, 1, 1, ST_UNREG, '0, 1'b0);
    dir_row(OP_SILENT, AddrHi, 2'd0, '0, '0, '0, 1'b0, '0, 1, 1, ST_UNREG, '0, 1'b0);
    dir_row(OP_REGISTER, AddrLo, 2'd0, '0, '0, '0, 1'b0, '0, 1, 1, ST_REGISTERED, '0, 1'b0);
    dir_row(OP_REGISTER, AddrLo, 2'd0, '0, '0, '0, 1'b0, '0, 1, 1, ST_DUP, '0, 1'b0);
    dir_row(OP_REGISTER, AddrHi, 2'd0, '0, '0, '0, 1'b1, '1, 1, 1, ST_REGISTERED, '0, 1'b0);
    dir_row(OP_POSITION, AddrLo, 2'd3, 32'h8000_0000, 32'h7fff_ffff, '1, 1'b0, '0,
            0, 0, ST_BAD, '0, 1'b0);
    dir_row(OP_POSITION, AddrLo, 2'd0, '1, '1, '1, 1'b0, '0, 0, 0, ST_BAD, '0, 1'b0);
    dir_row(OP_POSITION, AddrHi, 2'd2, '1, 32'h8000_0000, '0, 1'b0, '0, 0, 0, ST_BAD, '0, 1'b0);
    // malformed reserve requests
    dir_row(OP_RESERVE, AddrLo, 2'd0, '0, '0, '0, 1'b0, 16'd3, 1, 1, ST_BAD, '0, 1'b0);
    dir_row(OP_RESERVE, AddrLo, 2'd0, '0, '0, '0, 1'b1, 16'h8000, 1, 1, ST_BAD, 16'h8000, 1'b1);
    dir_row(OP_RESERVE, AddrLo, 2'd0, '0, '0, '0, 1'b1, 16'h7fff, 1, 1, ST_BAD, 16'h7fff, 1'b1);
    dir_row(OP_RESERVE, AddrLo, 2'd0, '0, '0, '0, 1'b1, 16'(NumResources), 1, 1, ST_BAD,
            16'(NumResources), 1'b1);
    // lock ownership
    dir_row(OP_RESERVE, AddrLo, 2'd0, '0, '0, '0, 1'b1, 16'd0, 0, 0, ST_BAD, '0, 1'b0);
    dir_row(OP_RESERVE, AddrLo, 2'd0, '0, '0, '0, 1'b1, 16'd0, 0, 0, ST_BAD, '0, 1'b0);
    dir_row(OP_RESERVE, AddrHi, 2'd0, '0, '0, '0, 1'b1, 16'd0, 0, 0, ST_BAD, '0, 1'b0);
    dir_row(OP_RELEASE, AddrHi, 2'd0, '0, '0, '0, 1'b1, 16'd0, 0, 0, ST_BAD, '0, 1'b0);
    dir_row(OP_RESERVE, AddrHi, 2'd0, '0, '0, '0, 1'b1, 16'(NumResources - 1), 0, 0, ST_BAD,
            '0, 1'b0);
    dir_row(OP_RELEASE, AddrLo, 2'd0, '0, '0, '0, 1'b1, 16'd0, 0, 0, ST_BAD, '0, 1'b0);
    dir_row(OP_RELEASE, AddrLo, 2'd0, '0, '0, '0, 1'b1, 16'd0, 0, 0, ST_BAD, '0, 1'b0);
    dir_row(OP_MISSION, AddrLo, 2'd0, '0, '0, '0, 1'b0, '0, 0, 0, ST_BAD, '0, 1'b0);
    dir_row(OP_SILENT, AddrLo, 2'd0, '0, '0, '0, 1'b0, '0, 1, 0, ST_BAD, '0, 1'b0);
    dir_row(OP_UNKNOWN, AddrLo, 2'd0, '0, '0, '0, 1'b1, 16'd1, 1, 1, ST_BAD, '0, 1'b0);
    dir_row(OP_RELEASE, AddrHi, 2'd0, '0, '0, '0, 1'b0, 16'd15, 1, 1, ST_BAD, '0, 1'b0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].has,
                                       dir_rows[i].rsp);
    drain_replies();

    for (int b = 0; b < RandItems / BlockItems; b++) begin
      // alternate random stalls with back-to-back stretches on either side
      tx_burst = (b % 4 == 1) || (b % 4 == 3);
      rx_burst = (b % 4 == 2) || (b % 4 == 3);
      if (b == (RandItems / BlockItems) / 2) drain_replies();
      for (int n = 0; n < BlockItems; n++) send_request(rand_request(), 1'b0, 1'b0, none);
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;

    drain_replies();
    repeat (DrainCycles) @(posedge clk_i);

    err_total = mismatch_cnt + unexpected_cnt + reply_due_q.size();
    $display("Ran %0d requests (%0d directed) over %0d client addresses;",
             accepted_cnt, dir_rows.size(), PoolSize);
    $display("%0d replies checked, %0d silent acks, %0d mismatches, %0d unexpected replies.",
             checked_cnt, silent_cnt, mismatch_cnt, unexpected_cnt);
    if (err_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
